FILE: rtl/sed_pkg.sv
// shared types, codes and helpers for the string escape decoder
`timescale 1ns / 1ps

package sed_pkg;

    // one input item
    typedef struct packed {
        logic [7:0] in_byte;
        logic       byte_present;
        logic       body_end;
    } sed_in_t;

    // one result item
    typedef struct packed {
        logic [7:0] decoded_byte;
        logic       emit_valid;
        logic [2:0] status;
        logic       body_done;
    } sed_out_t;

    // decoder modes
    localparam logic [1:0] MODE_NORMAL = 2'd0;
    localparam logic [1:0] MODE_ESCAPE = 2'd1;
    localparam logic [1:0] MODE_HEX    = 2'd2;
    localparam logic [1:0] MODE_ERROR  = 2'd3;

    // status codes
    localparam logic [2:0] ST_OK        = 3'd0;
    localparam logic [2:0] ST_QUOTE     = 3'd1;
    localparam logic [2:0] ST_DANGLING  = 3'd2;
    localparam logic [2:0] ST_TRUNCATED = 3'd3;
    localparam logic [2:0] ST_BAD_HEX   = 3'd4;
    localparam logic [2:0] ST_NON_ASCII = 3'd5;
    localparam logic [2:0] ST_UNKNOWN   = 3'd6;

    localparam logic [15:0] ASCII_MAX   = 16'h007F;
    localparam logic [2:0]  HEX_DIGITS  = 3'd4;

    localparam logic [7:0] CH_QUOTE     = 8'h22;
    localparam logic [7:0] CH_BACKSLASH = 8'h5C;
    localparam logic [7:0] CH_N         = 8'h6E;
    localparam logic [7:0] CH_T         = 8'h74;
    localparam logic [7:0] CH_R         = 8'h72;
    localparam logic [7:0] CH_U         = 8'h75;
    localparam logic [7:0] CH_LF        = 8'h0A;
    localparam logic [7:0] CH_TAB       = 8'h09;
    localparam logic [7:0] CH_CR        = 8'h0D;

    // bit 4 set means not a hex digit
    function automatic logic [4:0] hex_value(input logic [7:0] c);
        logic [4:0] v;
        v = 5'd16;
        if (c >= 8'h30 && c <= 8'h39)
        begin
            v = {1'b0, 4'(c - 8'h30)};
        end
        else if (c >= 8'h61 && c <= 8'h66)
        begin
            v = {1'b0, 4'(c - 8'h57)};
        end
        else if (c >= 8'h41 && c <= 8'h46)
        begin
            v = {1'b0, 4'(c - 8'h37)};
        end
        return v;
    endfunction

endpackage

FILE: rtl/sed_core.sv
// escape decoding state and per-item decode logic
`timescale 1ns / 1ps

module sed_core (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            step,
    input  sed_pkg::sed_in_t  item,
    output sed_pkg::sed_out_t result
);
    import sed_pkg::*;

    logic [1:0]  mode_reg, mode_next, mode_mid;
    logic [2:0]  count_reg, count_next, count_inc;
    logic [15:0] accum_reg, accum_next, accum_shift;
    logic        bad_reg, bad_next, bad_mid;
    logic [2:0]  err_reg, err_next, err_mid;
    logic        emit;
    logic [7:0]  byte_out;
    logic [4:0]  hv;

    assign hv          = hex_value(item.in_byte);
    assign count_inc   = count_reg + 3'd1;
    assign bad_mid     = bad_reg | hv[4];
    assign accum_shift = {accum_reg[11:0], (hv[4] ? 4'd0 : hv[3:0])};

    always_comb
    begin
        mode_next  = mode_reg;
        count_next = count_reg;
        accum_next = accum_reg;
        bad_next   = bad_reg;
        err_next   = err_reg;
        emit       = 1'b0;
        byte_out   = 8'd0;

        if (item.byte_present)
        begin
            case (mode_reg)
                MODE_NORMAL:
                begin
                    if (item.in_byte == CH_QUOTE)
                    begin
                        mode_next = MODE_ERROR;
                        if (err_reg == ST_OK)
                        begin
                            err_next = ST_QUOTE;
                        end
                    end
                    else if (item.in_byte == CH_BACKSLASH)
                    begin
                        mode_next = MODE_ESCAPE;
                    end
                    else
                    begin
                        emit     = 1'b1;
                        byte_out = item.in_byte;
                    end
                end
                MODE_ESCAPE:
                begin
                    mode_next = MODE_NORMAL;
                    if (item.in_byte == CH_BACKSLASH || item.in_byte == CH_QUOTE)
                    begin
                        emit     = 1'b1;
                        byte_out = item.in_byte;
                    end
                    else if (item.in_byte == CH_N)
                    begin
                        emit     = 1'b1;
                        byte_out = CH_LF;
                    end
                    else if (item.in_byte == CH_T)
                    begin
                        emit     = 1'b1;
                        byte_out = CH_TAB;
                    end
                    else if (item.in_byte == CH_R)
                    begin
                        emit     = 1'b1;
                        byte_out = CH_CR;
                    end
                    else if (item.in_byte == CH_U)
                    begin
                        mode_next  = MODE_HEX;
                        count_next = 3'd0;
                        accum_next = 16'd0;
                        bad_next   = 1'b0;
                    end
                    else
                    begin
                        mode_next = MODE_ERROR;
                        if (err_reg == ST_OK)
                        begin
                            err_next = ST_UNKNOWN;
                        end
                    end
                end
                MODE_HEX:
                begin
                    bad_next   = bad_mid;
                    accum_next = accum_shift;
                    count_next = count_inc;
                    if (count_inc >= HEX_DIGITS)
                    begin
                        count_next = 3'd0;
                        if (bad_mid)
                        begin
                            mode_next = MODE_ERROR;
                            if (err_reg == ST_OK)
                            begin
                                err_next = ST_BAD_HEX;
                            end
                        end
                        else if (accum_shift > ASCII_MAX)
                        begin
                            mode_next = MODE_ERROR;
                            if (err_reg == ST_OK)
                            begin
                                err_next = ST_NON_ASCII;
                            end
                        end
                        else
                        begin
                            emit      = 1'b1;
                            byte_out  = accum_shift[7:0];
                            mode_next = MODE_NORMAL;
                        end
                    end
                end
                default:
                begin
                    mode_next = mode_reg;
                end
            endcase
        end

        mode_mid = mode_next;
        err_mid  = err_next;

        // end of body inside an escape or a hex sequence
        if (item.body_end)
        begin
            if (mode_mid == MODE_ESCAPE && err_mid == ST_OK)
            begin
                err_next = ST_DANGLING;
            end
            else if (mode_mid == MODE_HEX && err_mid == ST_OK)
            begin
                err_next = ST_TRUNCATED;
            end
        end

        result.decoded_byte = byte_out;
        result.emit_valid   = emit;
        result.status       = err_next;
        result.body_done    = item.body_end;

        if (item.body_end)
        begin
            mode_next  = MODE_NORMAL;
            count_next = 3'd0;
            accum_next = 16'd0;
            bad_next   = 1'b0;
            err_next   = ST_OK;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg  <= MODE_NORMAL;
            count_reg <= 3'd0;
            accum_reg <= 16'd0;
            bad_reg   <= 1'b0;
            err_reg   <= ST_OK;
        end
        else if (step)
        begin
            mode_reg  <= mode_next;
            count_reg <= count_next;
            accum_reg <= accum_next;
            bad_reg   <= bad_next;
            err_reg   <= err_next;
        end
    end

endmodule

FILE: rtl/string_escape_decoder.sv
// top level: input register, decode core and result register
// an item moves from the input register through the decode core into the result register
// throughput: one item per cycle unless stalled; decode is single-pass between registers
// the input register takes a new item whenever it is empty or the result register moves on
// reset clears the decode state and both valid flags; payload registers are not reset
`timescale 1ns / 1ps

module string_escape_decoder (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              item_valid,
    output logic              item_stall,
    input  sed_pkg::sed_in_t  item,
    output logic              result_valid,
    input  logic              result_stall,
    output sed_pkg::sed_out_t result
);
    import sed_pkg::*;

    logic      in_valid_reg;
    sed_in_t   in_item_reg;
    logic      out_valid_reg;
    sed_out_t  out_item_reg;
    sed_out_t  decoded;
    logic      out_advance;
    logic      in_advance;

    assign out_advance = !out_valid_reg || !result_stall;
    assign in_advance  = !in_valid_reg || out_advance;
    assign item_stall  = !in_advance;

    sed_core u_core (
        .clk    (clk),
        .rst_n  (rst_n),
        .step   (in_valid_reg && out_advance),
        .item   (in_item_reg),
        .result (decoded)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (in_advance)
            begin
                in_valid_reg <= item_valid;
            end
            if (out_advance)
            begin
                out_valid_reg <= in_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_advance && item_valid)
        begin
            in_item_reg <= item;
        end
        if (out_advance && in_valid_reg)
        begin
            out_item_reg <= decoded;
        end
    end

    assign result_valid = out_valid_reg;
    assign result       = out_item_reg;

    // a decoded byte never comes with an error
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result.emit_valid |-> result.status == ST_OK)
        else $error("byte emitted with error status");

    // status code stays within the defined codes
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> result.status <= ST_UNKNOWN)
        else $error("undefined status code");

    // input side only stalls when both registers are full and the output is held
    assert property (@(posedge clk) disable iff (!rst_n)
        item_stall |-> in_valid_reg && out_valid_reg && result_stall)
        else $error("input stalled with room in the pipeline");

    // a held result does not vanish
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result_stall |=> result_valid)
        else $error("held result dropped");

endmodule
